/* rtl/core/mrfp_pkg.sv */
// Shared types, codes and helper functions of the modem receive frame parser.
package mrfp_pkg;

    // Longest text line in bytes, CR LF included
    localparam int MAX_LINE = 256;
    // Room for payload and held bytes after prefix, address, CR LF, next byte
    localparam logic [10:0] TEXT_ROOM = 11'(MAX_LINE - 9);

    // Reset value of the binary payload limit
    localparam logic [9:0] MAX_LEN_RESET = 10'd150;

    // Characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_R  = "R";
    localparam logic [7:0] CH_X  = "X";
    localparam logic [7:0] CH_T  = "T";
    localparam logic [7:0] CH_B  = "B";
    localparam logic [7:0] CH_N  = "N";
    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_9  = "9";

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_TEXT_END  = 3'd1;
    localparam logic [2:0] KIND_BIN_END   = 3'd2;
    localparam logic [2:0] KIND_TOO_LONG  = 3'd3;
    localparam logic [2:0] KIND_MALFORMED = 3'd4;

    // Parser phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_R      = 4'd1,
        PH_RX     = 4'd2,
        PH_RB     = 4'd3,
        PH_ADDR_T = 4'd4,
        PH_ADDR_B = 4'd5,
        PH_LEN    = 4'd6,
        PH_TEXT   = 4'd7,
        PH_BPAY   = 4'd8,
        PH_BLVL   = 4'd9,
        PH_BTAIL  = 4'd10,
        PH_SKIP   = 4'd11
    } t_phase;

    // One result record between parser and output stage
    typedef struct packed {
        logic       vld;
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [9:0] sender_addr;
        logic [9:0] payload_len;
        logic [9:0] signal_level;
    } t_result;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    // Decimal accumulate, wrapped to 10 bits
    function automatic logic [9:0] acc_digit(input logic [9:0] acc, input logic [7:0] b);
        logic [13:0] sum;
        sum = 14'({acc, 3'b000}) + 14'({acc, 1'b0}) + 14'(b[3:0]);
        return sum[9:0];
    endfunction

endpackage

/* rtl/core/mrfp_if.sv */
// Stream interfaces for received bytes and parser results.
interface mrfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrfp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [9:0] sender_addr;
    logic [9:0] payload_len;
    logic [9:0] signal_level;

    modport source (output valid, output kind, output data_byte, output sender_addr,
                    output payload_len, output signal_level, input ready);
    modport sink   (input valid, input kind, input data_byte, input sender_addr,
                    input payload_len, input signal_level, output ready);
endinterface

/* rtl/core/modem_rx_frame_parser.sv */
// Top level: modem receive-line parser, byte in, payload and frame records out.
// A result reaches the output through the input register, a parser step and the result register.
// Throughput: one byte per cycle while the result register has room; parser state is registered.
// A result waiting at the output does not block input until both registers are full.
// Reset (synchronous, active low): parser idle, all line state cleared, payload limit 150.
module modem_rx_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    mrfp_in_if.sink     i_rx,
    mrfp_out_if.source  o_res
);

    logic              w_in_vld;
    logic [7:0]        w_in_byte;
    logic              w_can_take;
    logic              w_step;
    mrfp_pkg::t_result w_res;

    // Step the parser when a byte is held and the result register has room
    assign w_step = w_in_vld && w_can_take;

    mrfp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_step),
        .o_vld     (w_in_vld),
        .o_byte    (w_in_byte)
    );

    mrfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_byte      (w_in_byte),
        .o_res       (w_res)
    );

    mrfp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_step),
        .i_res      (w_res),
        .o_can_take (w_can_take),
        .o_res      (o_res)
    );

    // A new result only appears after a parser step
    a_res_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_step))
        else $error("result appeared without a parser step");

    // Payload data only rides on payload transactions
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind != mrfp_pkg::KIND_PAYLOAD)) |-> (o_res.data_byte == 8'd0))
        else $error("data byte set on a non-payload record");

    // Parser never steps while the result register is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !w_step)
        else $error("parser stepped into a full result register");

endmodule

/* rtl/core/mrfp_in_stage.sv */
// Input register: holds one accepted byte until the parser steps on it.
module mrfp_in_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrfp_in_if.sink     i_rx,
    input  logic        i_advance,
    output logic        o_vld,
    output logic [7:0]  o_byte
);

    logic       r_vld;
    logic [7:0] r_byte;

    // Free when empty or when the held byte moves on this cycle
    assign i_rx.ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_vld <= 1'b1;
        end else if (i_advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;

endmodule

/* rtl/core/mrfp_parser.sv */
// Line parser state machine: one byte per step, at most one result per step.
module mrfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_wdata,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output mrfp_pkg::t_result o_res
);

    mrfp_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_fp, n_fp;
    logic [9:0]  r_addr, n_addr;
    logic [9:0]  r_len, n_len;
    logic [9:0]  r_pc, n_pc;
    logic [9:0]  r_lvl, n_lvl;
    logic [7:0]  r_hold [3];
    logic [7:0]  n_hold [3];
    logic [1:0]  r_fill, n_fill;
    logic        r_saw_cr, n_saw_cr;
    logic        r_bad, n_bad;
    logic [9:0]  r_max_len;

    logic        w_digit;
    logic        w_fp_last;
    logic [1:0]  w_fp_inc;
    logic [9:0]  w_addr_nx, w_len_nx, w_lvl_nx, w_pc_inc;
    logic        w_is_lf, w_is_cr;
    logic        w_text_ok, w_overlong;
    logic [9:0]  w_hold_lvl;
    mrfp_pkg::t_result w_res;

    // Shared decode of the current byte
    assign w_digit   = mrfp_pkg::is_digit(i_byte);
    assign w_is_lf   = (i_byte == mrfp_pkg::CH_LF);
    assign w_is_cr   = (i_byte == mrfp_pkg::CH_CR);
    assign w_fp_last = (r_fp == 2'd2);
    assign w_fp_inc  = w_fp_last ? 2'd0 : r_fp + 2'd1;
    assign w_addr_nx = mrfp_pkg::acc_digit(r_addr, i_byte);
    assign w_len_nx  = mrfp_pkg::acc_digit(r_len, i_byte);
    assign w_lvl_nx  = mrfp_pkg::acc_digit(r_lvl, i_byte);
    assign w_pc_inc  = r_pc + 10'd1;

    // Text tail check and intensity from the three held bytes
    assign w_text_ok = (r_phase == mrfp_pkg::PH_TEXT) && r_saw_cr && (r_fill == 2'd3) &&
                       mrfp_pkg::is_digit(r_hold[0]) && mrfp_pkg::is_digit(r_hold[1]) &&
                       mrfp_pkg::is_digit(r_hold[2]);
    assign w_hold_lvl = 10'(r_hold[0][3:0]) * 10'd100 + 10'(r_hold[1][3:0]) * 10'd10 +
                        10'(r_hold[2][3:0]);
    assign w_overlong = (11'(r_pc) + 11'(r_fill)) > mrfp_pkg::TEXT_ROOM;

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_fp     = r_fp;
        n_addr   = r_addr;
        n_len    = r_len;
        n_pc     = r_pc;
        n_lvl    = r_lvl;
        n_hold   = r_hold;
        n_fill   = r_fill;
        n_saw_cr = r_saw_cr;
        n_bad    = r_bad;
        if (r_phase == mrfp_pkg::PH_BPAY) begin
            n_pc = w_pc_inc;
            if (w_pc_inc >= r_len) begin
                n_phase = r_bad ? mrfp_pkg::PH_SKIP : mrfp_pkg::PH_BLVL;
                n_fp    = 2'd0;
            end
        end else if (w_is_lf) begin
            if (r_phase != mrfp_pkg::PH_IDLE) begin
                n_phase  = mrfp_pkg::PH_IDLE;
                n_fp     = 2'd0;
                n_addr   = '0;
                n_len    = '0;
                n_pc     = '0;
                n_lvl    = '0;
                n_hold   = '{default: 8'd0};
                n_fill   = 2'd0;
                n_saw_cr = 1'b0;
                n_bad    = 1'b0;
            end
        end else begin
            case (r_phase)
                mrfp_pkg::PH_IDLE: begin
                    if (!w_is_cr) begin
                        n_fp     = 2'd0;
                        n_addr   = '0;
                        n_len    = '0;
                        n_pc     = '0;
                        n_lvl    = '0;
                        n_hold   = '{default: 8'd0};
                        n_fill   = 2'd0;
                        n_saw_cr = 1'b0;
                        if (i_byte == mrfp_pkg::CH_R) begin
                            n_phase = mrfp_pkg::PH_R;
                            n_bad   = 1'b0;
                        end else begin
                            n_phase = mrfp_pkg::PH_SKIP;
                            n_bad   = 1'b1;
                        end
                    end
                end
                mrfp_pkg::PH_R: begin
                    if (i_byte == mrfp_pkg::CH_X) begin
                        n_phase = mrfp_pkg::PH_RX;
                    end else if (i_byte == mrfp_pkg::CH_B) begin
                        n_phase = mrfp_pkg::PH_RB;
                    end else begin
                        n_phase = mrfp_pkg::PH_SKIP;
                        n_bad   = 1'b1;
                    end
                end
                mrfp_pkg::PH_RX, mrfp_pkg::PH_RB: begin
                    if ((r_phase == mrfp_pkg::PH_RX) && (i_byte == mrfp_pkg::CH_T)) begin
                        n_phase = mrfp_pkg::PH_ADDR_T;
                        n_fp    = 2'd0;
                    end else if ((r_phase == mrfp_pkg::PH_RB) && (i_byte == mrfp_pkg::CH_N)) begin
                        n_phase = mrfp_pkg::PH_ADDR_B;
                        n_fp    = 2'd0;
                    end else begin
                        n_phase = mrfp_pkg::PH_SKIP;
                        n_bad   = 1'b1;
                    end
                end
                mrfp_pkg::PH_ADDR_T, mrfp_pkg::PH_ADDR_B: begin
                    if (!w_digit) begin
                        n_phase = mrfp_pkg::PH_SKIP;
                        n_bad   = 1'b1;
                    end else begin
                        n_addr = w_addr_nx;
                        n_fp   = w_fp_inc;
                        if (w_fp_last) begin
                            n_phase = (r_phase == mrfp_pkg::PH_ADDR_T) ?
                                      mrfp_pkg::PH_TEXT : mrfp_pkg::PH_LEN;
                        end
                    end
                end
                mrfp_pkg::PH_LEN: begin
                    if (!w_digit) begin
                        n_phase = mrfp_pkg::PH_SKIP;
                        n_bad   = 1'b1;
                    end else begin
                        n_len = w_len_nx;
                        n_fp  = w_fp_inc;
                        if (w_fp_last) begin
                            if (w_len_nx > r_max_len) begin
                                n_bad   = 1'b1;
                                n_phase = mrfp_pkg::PH_BPAY;
                            end else if (w_len_nx == 10'd0) begin
                                n_phase = mrfp_pkg::PH_BLVL;
                            end else begin
                                n_phase = mrfp_pkg::PH_BPAY;
                            end
                        end
                    end
                end
                mrfp_pkg::PH_BLVL: begin
                    if (!w_digit) begin
                        n_phase = mrfp_pkg::PH_SKIP;
                        n_bad   = 1'b1;
                    end else begin
                        n_lvl = w_lvl_nx;
                        n_fp  = w_fp_inc;
                        if (w_fp_last) begin
                            n_phase  = mrfp_pkg::PH_BTAIL;
                            n_saw_cr = 1'b0;
                        end
                    end
                end
                mrfp_pkg::PH_BTAIL: begin
                    if (w_is_cr && !r_saw_cr) begin
                        n_saw_cr = 1'b1;
                    end else begin
                        n_phase = mrfp_pkg::PH_SKIP;
                        n_bad   = 1'b1;
                    end
                end
                mrfp_pkg::PH_TEXT: begin
                    if (r_saw_cr || (!w_is_cr && w_overlong)) begin
                        n_phase = mrfp_pkg::PH_SKIP;
                        n_bad   = 1'b1;
                    end else if (w_is_cr) begin
                        n_saw_cr = 1'b1;
                    end else if (r_fill != 2'd3) begin
                        n_hold[r_fill] = i_byte;
                        n_fill         = r_fill + 2'd1;
                    end else begin
                        n_hold[0] = r_hold[1];
                        n_hold[1] = r_hold[2];
                        n_hold[2] = i_byte;
                        n_pc      = w_pc_inc;
                    end
                end
                mrfp_pkg::PH_SKIP: begin
                end
                default: begin
                    n_phase  = mrfp_pkg::PH_IDLE;
                    n_fp     = 2'd0;
                    n_addr   = '0;
                    n_len    = '0;
                    n_pc     = '0;
                    n_lvl    = '0;
                    n_hold   = '{default: 8'd0};
                    n_fill   = 2'd0;
                    n_saw_cr = 1'b0;
                    n_bad    = 1'b0;
                end
            endcase
        end
    end

    // Result of the current step
    always_comb begin
        w_res = '0;
        if (r_phase == mrfp_pkg::PH_BPAY) begin
            w_res.vld       = !r_bad;
            w_res.kind      = mrfp_pkg::KIND_PAYLOAD;
            w_res.data_byte = r_bad ? 8'd0 : i_byte;
        end else if (w_is_lf) begin
            if (r_phase == mrfp_pkg::PH_IDLE || r_phase == mrfp_pkg::PH_SKIP) begin
                w_res.vld = 1'b0;
            end else if (w_text_ok) begin
                w_res.vld          = 1'b1;
                w_res.kind         = mrfp_pkg::KIND_TEXT_END;
                w_res.sender_addr  = r_addr;
                w_res.payload_len  = r_pc;
                w_res.signal_level = w_hold_lvl;
            end else if ((r_phase == mrfp_pkg::PH_BTAIL) && r_saw_cr) begin
                w_res.vld          = 1'b1;
                w_res.kind         = mrfp_pkg::KIND_BIN_END;
                w_res.sender_addr  = r_addr;
                w_res.payload_len  = r_pc;
                w_res.signal_level = r_lvl;
            end else begin
                w_res.vld  = 1'b1;
                w_res.kind = mrfp_pkg::KIND_MALFORMED;
            end
        end else begin
            // Malformed by default; arms below clear or replace it
            w_res.kind = mrfp_pkg::KIND_MALFORMED;
            case (r_phase)
                mrfp_pkg::PH_IDLE:
                    w_res.vld = !w_is_cr && (i_byte != mrfp_pkg::CH_R);
                mrfp_pkg::PH_R:
                    w_res.vld = (i_byte != mrfp_pkg::CH_X) && (i_byte != mrfp_pkg::CH_B);
                mrfp_pkg::PH_RX:
                    w_res.vld = (i_byte != mrfp_pkg::CH_T);
                mrfp_pkg::PH_RB:
                    w_res.vld = (i_byte != mrfp_pkg::CH_N);
                mrfp_pkg::PH_ADDR_T, mrfp_pkg::PH_ADDR_B, mrfp_pkg::PH_BLVL:
                    w_res.vld = !w_digit;
                mrfp_pkg::PH_LEN: begin
                    if (!w_digit) begin
                        w_res.vld = 1'b1;
                    end else if (w_fp_last && (w_len_nx > r_max_len)) begin
                        w_res.vld         = 1'b1;
                        w_res.kind        = mrfp_pkg::KIND_TOO_LONG;
                        w_res.sender_addr = r_addr;
                        w_res.payload_len = w_len_nx;
                    end
                end
                mrfp_pkg::PH_BTAIL:
                    w_res.vld = !(w_is_cr && !r_saw_cr);
                mrfp_pkg::PH_TEXT: begin
                    if (r_saw_cr || (!w_is_cr && w_overlong)) begin
                        w_res.vld = 1'b1;
                    end else if (!w_is_cr && (r_fill == 2'd3)) begin
                        w_res.vld       = 1'b1;
                        w_res.kind      = mrfp_pkg::KIND_PAYLOAD;
                        w_res.data_byte = r_hold[0];
                    end
                end
                default:
                    w_res.vld = 1'b0;
            endcase
        end
    end

    always_comb begin
        o_res     = w_res;
        o_res.vld = i_step && w_res.vld;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= mrfp_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // Parser state, advanced once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mrfp_pkg::PH_IDLE;
            r_fp     <= 2'd0;
            r_addr   <= '0;
            r_len    <= '0;
            r_pc     <= '0;
            r_lvl    <= '0;
            r_hold   <= '{default: 8'd0};
            r_fill   <= 2'd0;
            r_saw_cr <= 1'b0;
            r_bad    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_fp     <= n_fp;
            r_addr   <= n_addr;
            r_len    <= n_len;
            r_pc     <= n_pc;
            r_lvl    <= n_lvl;
            r_hold   <= n_hold;
            r_fill   <= n_fill;
            r_saw_cr <= n_saw_cr;
            r_bad    <= n_bad;
        end
    end

endmodule

/* rtl/core/mrfp_out_stage.sv */
// Result register: holds one result transaction until the sink takes it.
module mrfp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  mrfp_pkg::t_result i_res,
    output logic              o_can_take,
    mrfp_out_if.source        o_res
);

    logic              r_vld;
    mrfp_pkg::t_result r_res;

    // Room for a new result when empty or when the current one leaves now
    assign o_can_take = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_advance) begin
            r_vld <= i_res.vld;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_vld;
    assign o_res.kind         = r_res.kind;
    assign o_res.data_byte    = r_res.data_byte;
    assign o_res.sender_addr  = r_res.sender_addr;
    assign o_res.payload_len  = r_res.payload_len;
    assign o_res.signal_level = r_res.signal_level;

endmodule

/* bench/tb_modem_rx_frame_parser.sv */
// Self-checking testbench for the modem receive-line parser: byte stream in, frame records out.
`timescale 1ns / 100ps

module tb_modem_rx_frame_parser;
    import mrfp_pkg::*;

    // Expected frame record, field for field as on the result channel
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [9:0] sender_addr;
        logic [9:0] payload_len;
        logic [9:0] signal_level;
    } rx_record_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [9:0] cfg_wdata;

    mrfp_in_if  rx_if ();
    mrfp_out_if res_if ();

    modem_rx_frame_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_rx       (rx_if.sink),
        .o_res      (res_if.source)
    );

    // Stimulus and scoreboard storage
    logic [7:0] serial_q[$];
    logic [7:0] line_buf[$];
    rx_record_t pending_recs[$];

    int bytes_queued = 0;
    int bytes_taken  = 0;
    int lines_sent   = 0;
    int recs_checked = 0;
    int mismatches   = 0;
    int kind_count[8];
    logic rx_taken = 1'b0;
    logic steady   = 1'b0;

    // Parser shadow state
    t_phase     pstate;
    logic [7:0] digit_idx;
    logic [9:0] addr_val;
    logic [9:0] len_val;
    logic [9:0] pay_cnt;
    logic [9:0] lvl_val;
    logic [7:0] tail_q[3];
    logic [1:0] tail_n;
    logic       got_cr;
    logic       dropping;
    logic [9:0] len_limit;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("tb: mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic logic digit_ok(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [9:0] dec_shift(input logic [9:0] acc, input logic [7:0] b);
        int v;
        v = int'(acc) * 10 + int'(b) - int'(CH_0);
        return 10'(v);
    endfunction

    // Advances the digit position; true once a three-digit field is complete
    function automatic logic field_full();
        digit_idx = digit_idx + 8'd1;
        if (digit_idx >= 8'd3) begin
            digit_idx = 8'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void start_line();
        digit_idx = '0;
        addr_val  = '0;
        len_val   = '0;
        pay_cnt   = '0;
        lvl_val   = '0;
        tail_q    = '{default: 8'd0};
        tail_n    = '0;
        got_cr    = 1'b0;
        dropping  = 1'b0;
    endfunction

    function automatic void push_rec(input logic [2:0] kind, input logic [7:0] data,
                                     input logic [9:0] addr, input logic [9:0] len,
                                     input logic [9:0] lvl);
        rx_record_t r;
        r.kind         = kind;
        r.data_byte    = data;
        r.sender_addr  = addr;
        r.payload_len  = len;
        r.signal_level = lvl;
        pending_recs.push_back(r);
    endfunction

    // Malformed: flag now, drop the rest of the line
    function automatic void reject();
        pstate   = PH_SKIP;
        dropping = 1'b1;
        push_rec(KIND_MALFORMED, 8'd0, 10'd0, 10'd0, 10'd0);
    endfunction

    // One received byte through the shadow parser
    function automatic void parse_rx_byte(input logic [7:0] b);
        int lv;
        if (pstate == PH_BPAY) begin
            // raw payload: LF is data here
            pay_cnt = pay_cnt + 10'd1;
            if (!dropping)
                push_rec(KIND_PAYLOAD, b, 10'd0, 10'd0, 10'd0);
            if (pay_cnt >= len_val) begin
                if (dropping) pstate = PH_SKIP;
                else          pstate = PH_BLVL;
                digit_idx = '0;
            end
        end else if (b == CH_LF) begin
            if (pstate != PH_IDLE) begin
                if (pstate == PH_SKIP) begin
                    // line already flagged
                end else if (pstate == PH_TEXT && got_cr && tail_n == 2'd3 &&
                             digit_ok(tail_q[0]) && digit_ok(tail_q[1]) &&
                             digit_ok(tail_q[2])) begin
                    lv = int'(tail_q[0] - CH_0) * 100 + int'(tail_q[1] - CH_0) * 10 +
                         int'(tail_q[2] - CH_0);
                    push_rec(KIND_TEXT_END, 8'd0, addr_val, pay_cnt, 10'(lv));
                end else if (pstate == PH_BTAIL && got_cr) begin
                    push_rec(KIND_BIN_END, 8'd0, addr_val, pay_cnt, lvl_val);
                end else begin
                    push_rec(KIND_MALFORMED, 8'd0, 10'd0, 10'd0, 10'd0);
                end
                pstate = PH_IDLE;
                start_line();
            end
        end else begin
            case (pstate)
                PH_IDLE: begin
                    if (b != CH_CR) begin
                        start_line();
                        if (b == CH_R) pstate = PH_R;
                        else           reject();
                    end
                end
                PH_R: begin
                    if (b == CH_X)      pstate = PH_RX;
                    else if (b == CH_B) pstate = PH_RB;
                    else                reject();
                end
                PH_RX: begin
                    if (b == CH_T) begin
                        pstate    = PH_ADDR_T;
                        digit_idx = '0;
                    end else begin
                        reject();
                    end
                end
                PH_RB: begin
                    if (b == CH_N) begin
                        pstate    = PH_ADDR_B;
                        digit_idx = '0;
                    end else begin
                        reject();
                    end
                end
                PH_ADDR_T, PH_ADDR_B: begin
                    if (!digit_ok(b)) begin
                        reject();
                    end else begin
                        addr_val = dec_shift(addr_val, b);
                        if (field_full()) begin
                            if (pstate == PH_ADDR_T) pstate = PH_TEXT;
                            else                     pstate = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    if (!digit_ok(b)) begin
                        reject();
                    end else begin
                        len_val = dec_shift(len_val, b);
                        if (field_full()) begin
                            if (len_val > len_limit) begin
                                // swallow the announced payload silently
                                dropping = 1'b1;
                                pstate   = PH_BPAY;
                                push_rec(KIND_TOO_LONG, 8'd0, addr_val, len_val, 10'd0);
                            end else if (len_val == 10'd0) begin
                                pstate = PH_BLVL;
                            end else begin
                                pstate = PH_BPAY;
                            end
                        end
                    end
                end
                PH_BLVL: begin
                    if (!digit_ok(b)) begin
                        reject();
                    end else begin
                        lvl_val = dec_shift(lvl_val, b);
                        if (field_full()) begin
                            pstate = PH_BTAIL;
                            got_cr = 1'b0;
                        end
                    end
                end
                PH_BTAIL: begin
                    if (b == CH_CR && !got_cr) got_cr = 1'b1;
                    else                       reject();
                end
                PH_TEXT: begin
                    if (got_cr) begin
                        reject();
                    end else if (b == CH_CR) begin
                        got_cr = 1'b1;
                    end else if (6 + int'(pay_cnt) + int'(tail_n) + 3 > MAX_LINE) begin
                        reject();
                    end else if (tail_n < 2'd3) begin
                        tail_q[tail_n] = b;
                        tail_n = tail_n + 2'd1;
                    end else begin
                        // oldest held byte is now certain to be text
                        push_rec(KIND_PAYLOAD, tail_q[0], 10'd0, 10'd0, 10'd0);
                        tail_q[0] = tail_q[1];
                        tail_q[1] = tail_q[2];
                        tail_q[2] = b;
                        pay_cnt   = pay_cnt + 10'd1;
                    end
                end
                PH_SKIP: begin
                end
                default: begin
                    pstate = PH_IDLE;
                    start_line();
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- driver

    // Byte source and result sink, both changing on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            rx_if.valid  <= 1'b0;
            res_if.ready <= 1'b0;
        end else begin
            if (!rx_if.valid || rx_taken) begin
                if (serial_q.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= serial_q.pop_front();
                end else begin
                    rx_if.valid   <= 1'b0;
                    rx_if.rx_byte <= 8'($urandom);
                end
            end
            res_if.ready <= steady || ($urandom_range(99) >= 28);
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_result();
        rx_record_t want;
        if (res_if.kind < 3'd5)
            kind_count[res_if.kind]++;
        recs_checked++;
        if (pending_recs.size() == 0) begin
            report_mismatch($sformatf("record kind %0d with nothing predicted", res_if.kind));
        end else begin
            want = pending_recs.pop_front();
            if (res_if.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, predicted %0d", res_if.kind, want.kind));
            if (res_if.data_byte !== want.data_byte)
                report_mismatch($sformatf("data_byte %0h, predicted %0h",
                                          res_if.data_byte, want.data_byte));
            if (res_if.sender_addr !== want.sender_addr)
                report_mismatch($sformatf("sender_addr %0d, predicted %0d",
                                          res_if.sender_addr, want.sender_addr));
            if (res_if.payload_len !== want.payload_len)
                report_mismatch($sformatf("payload_len %0d, predicted %0d",
                                          res_if.payload_len, want.payload_len));
            if (res_if.signal_level !== want.signal_level)
                report_mismatch($sformatf("signal_level %0d, predicted %0d",
                                          res_if.signal_level, want.signal_level));
        end
    endtask

    // Accepted transactions on both channels, sampled on the rising edge
    always @(posedge clk) begin
        rx_taken = 1'b0;
        if (rst_n) begin
            if (rx_if.valid === 1'b1 && rx_if.ready === 1'b1) begin
                rx_taken = 1'b1;
                bytes_taken++;
                parse_rx_byte(rx_if.rx_byte);
            end
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
                check_result();
        end
    end

    // ---------------------------------------------------------------- line builders

    task automatic put(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_num(input int v);
        put(CH_0 + 8'(v / 100));
        put(CH_0 + 8'((v / 10) % 10));
        put(CH_0 + 8'(v % 10));
    endtask

    task automatic end_line();
        put(CH_CR);
        put(CH_LF);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic make_text(input int addr, input int n, input int lvl);
        put(CH_R); put(CH_X); put(CH_T);
        put_num(addr);
        repeat (n) put(text_char());
        put_num(lvl);
        end_line();
    endtask

    task automatic make_bin(input int addr, input int n, input int lvl);
        put(CH_R); put(CH_B); put(CH_N);
        put_num(addr);
        put_num(n);
        repeat (n) put(8'($urandom));
        put_num(lvl);
        end_line();
    endtask

    task automatic commit_line();
        foreach (line_buf[i])
            serial_q.push_back(line_buf[i]);
        bytes_queued += line_buf.size();
        lines_sent++;
        line_buf.delete();
    endtask

    // Binary length: mostly small, with the limit edges when the limit is short
    function automatic int pick_len();
        int r;
        r = $urandom_range(9);
        if (len_limit <= 10'd40 && r == 8)
            return int'(len_limit);
        if (len_limit <= 10'd40 && r == 9)
            return int'(len_limit) + 1 + $urandom_range(2);
        return $urandom_range((len_limit < 10'd12) ? int'(len_limit) : 12);
    endfunction

    // Mostly well-formed lines with random content, the rest noise and damaged lines
    task automatic random_line();
        int sel;
        int addr;
        int lvl;
        int k;
        sel  = $urandom_range(99);
        addr = $urandom_range(999);
        lvl  = $urandom_range(999);
        if (sel < 40) begin
            make_text(addr, $urandom_range(($urandom_range(9) == 0) ? 40 : 8), lvl);
        end else if (sel < 75) begin
            make_bin(addr, pick_len(), lvl);
        end else if (sel < 80) begin
            repeat ($urandom_range(1, 6)) put(8'($urandom));
            put(CH_LF);
        end else begin
            if (sel < 88) make_text(addr, $urandom_range(6), lvl);
            else          make_bin(addr, pick_len(), lvl);
            k = $urandom_range(line_buf.size() - 2);
            case ($urandom_range(2))
                0: line_buf[k] = 8'($urandom);
                1: begin
                    // cut the line short
                    while (line_buf.size() > k + 1)
                        void'(line_buf.pop_back());
                    put(CH_LF);
                end
                default: line_buf.insert(k, 8'($urandom));
            endcase
        end
        commit_line();
    endtask

    // Waits until every byte is taken and every predicted record has arrived, or reports a timeout
    task automatic drain();
        int waited;
        waited = 0;
        while ((bytes_taken < bytes_queued || pending_recs.size() != 0) && waited < 20000) begin
            @(negedge clk);
            waited++;
        end
        if (waited >= 20000)
            report_mismatch($sformatf("%0d records still outstanding", pending_recs.size()));
        repeat (8) @(negedge clk);
    endtask

    task automatic set_len_limit(input logic [9:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        len_limit = v;
    endtask

    // ---------------------------------------------------------------- stimulus

    initial begin
        int start;
        int calm_phase;
        logic [9:0] mid_limit;
        logic [9:0] limits[5];

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        pstate        = PH_IDLE;
        len_limit     = MAX_LEN_RESET;
        start_line();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines under the reset limit
        put(CH_CR); put(CH_LF); put(CH_CR); commit_line();
        make_text(0, 1, 0); commit_line();
        make_text(999, 0, 999); commit_line();
        make_bin(123, 0, 456); commit_line();
        put_str("RBN007004");
        put(8'h00); put(CH_LF); put(CH_CR); put(8'hFF);
        put_num(42); end_line(); commit_line();
        make_bin(321, 151, 77); commit_line();
        put_str("QXT"); put(CH_LF); commit_line();
        put_str("RXA"); put(CH_LF); commit_line();
        put_str("RBX"); put(CH_LF); commit_line();
        put_str("R"); put(CH_LF); commit_line();
        put_str("RXT1a2x"); put(CH_LF); commit_line();
        put_str("RBN0010x5"); put(CH_LF); commit_line();
        put_str("RBN12"); put(CH_LF); commit_line();
        put_str("RBN001001Z12"); end_line(); commit_line();
        put_str("RXT12"); put(CH_LF); commit_line();
        put_str("RXT001hi4x6"); end_line(); commit_line();
        put_str("RXT00112"); end_line(); commit_line();
        put_str("RXT001hi123"); put(CH_CR); put_str("Z"); put(CH_LF); commit_line();
        put_str("RXT005abc"); put(CH_LF); commit_line();
        put_str("RBN001000555X"); put(CH_LF); commit_line();
        put_str("RBN001000555"); put(CH_CR); end_line(); commit_line();
        put_str("RBN001000555"); put(CH_LF); commit_line();
        // text line that fills the line limit and then runs one byte over
        make_text(43, 246, 251); commit_line();
        drain();

        // Random phases over several payload limits, one of them without stalls
        mid_limit  = 10'($urandom_range(1, 998));
        limits     = '{10'd0, 10'd7, 10'd999, mid_limit, MAX_LEN_RESET};
        calm_phase = $urandom_range(0, 3);
        for (int p = 0; p < 5; p++) begin
            set_len_limit(limits[p]);
            steady = (p == calm_phase);
            start = bytes_queued;
            while (bytes_queued - start < 20)
                random_line();
            drain();
        end
        steady = 1'b0;

        $display("tb: %0d bytes in %0d lines, %0d records checked, limits 150 0 7 999 %0d",
                 bytes_taken, lines_sent, recs_checked, mid_limit);
        $display("tb: payload %0d, text end %0d, binary end %0d, too long %0d, malformed %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
